// ----- design/spe_pkg.sv -----
// Shared types, widths, register codes and helpers for the spline point evaluator.
`default_nettype none

package spe_pkg;

  // Field and datapath widths
  localparam int TIME_W    = 24;
  localparam int COEF_W    = 32;
  localparam int ACC_W     = 40;
  localparam int PROD_W    = ACC_W + TIME_W + 1;
  localparam int NCOEF     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NSTEP     = NCOEF - 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF5 = 3'd6;

  // Segment order codes
  localparam logic [1:0] ORDER_LINEAR  = 2'd0;
  localparam logic [1:0] ORDER_CUBIC   = 2'd1;
  localparam logic [1:0] ORDER_QUINTIC = 2'd2;

  typedef logic        [TIME_W-1:0] time_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Accumulator limits
  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // One item in flight between Horner steps: time, three accumulators and a saturation flag
  typedef struct packed {
    time_t t;
    acc_t  pos;
    acc_t  vel;
    acc_t  acc;
    logic  sat;
  } horner_word_t;

  // Scale a coefficient by a small derivative factor
  function automatic acc_t scale_coef(input coef_t c, input logic [4:0] k);
    acc_t ce;
    acc_t ke;
    ce = acc_t'(c);
    ke = acc_t'(k);
    return ce * ke;
  endfunction

endpackage

`default_nettype wire

// ----- design/spe_step.sv -----
// One Horner step for three lanes: multiply stage, then round, add and clamp stage.
`default_nettype none

module spe_step import spe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire horner_word_t in_word,
  input  wire acc_t         coef_pos,
  input  wire acc_t         coef_vel,
  input  wire acc_t         coef_acc,
  output logic              out_valid,
  input  wire logic         out_ready,
  output horner_word_t      out_word
);

  localparam int SUM_W = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  // Round half up, add the next coefficient, clamp to the accumulator range
  function automatic logic [ACC_W:0] round_add(input prod_t p, input acc_t c);
    logic signed [SUM_W-1:0] pe;
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] s;
    logic [ACC_W:0]          res;
    pe = SUM_W'(p);
    q  = (pe + HALF) >>> FRAC_BITS;
    s  = q + SUM_W'(c);
    if (s > SUM_W'(ACC_MAX)) begin
      res = {1'b1, ACC_MAX};
    end else if (s < SUM_W'(ACC_MIN)) begin
      res = {1'b1, ACC_MIN};
    end else begin
      res = {1'b0, s[ACC_W-1:0]};
    end
    return res;
  endfunction

  logic  m_valid_r;
  time_t m_t_r;
  prod_t m_pos_r, m_vel_r, m_acc_r;
  logic  m_sat_r;
  logic  a_valid_r;
  horner_word_t a_word_r;

  logic  m_ready, a_ready;
  prod_t pos_nxt, vel_nxt, acc_nxt;
  logic [ACC_W:0] pos_sum, vel_sum, acc_sum;
  horner_word_t a_word_nxt;

  assign a_ready  = !a_valid_r || out_ready;
  assign m_ready  = !m_valid_r || a_ready;
  assign in_ready = m_ready;

  // Multiply each accumulator by time
  always_comb begin
    pos_nxt = $signed(in_word.pos) * $signed({1'b0, in_word.t});
    vel_nxt = $signed(in_word.vel) * $signed({1'b0, in_word.t});
    acc_nxt = $signed(in_word.acc) * $signed({1'b0, in_word.t});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_ready) begin
      m_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready) begin
      m_t_r   <= in_word.t;
      m_pos_r <= pos_nxt;
      m_vel_r <= vel_nxt;
      m_acc_r <= acc_nxt;
      m_sat_r <= in_word.sat;
    end
  end

  // Round, add and clamp
  always_comb begin
    pos_sum          = round_add(m_pos_r, coef_pos);
    vel_sum          = round_add(m_vel_r, coef_vel);
    acc_sum          = round_add(m_acc_r, coef_acc);
    a_word_nxt.t     = m_t_r;
    a_word_nxt.pos   = pos_sum[ACC_W-1:0];
    a_word_nxt.vel   = vel_sum[ACC_W-1:0];
    a_word_nxt.acc   = acc_sum[ACC_W-1:0];
    a_word_nxt.sat   = m_sat_r | pos_sum[ACC_W] | vel_sum[ACC_W] | acc_sum[ACC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_word_r <= a_word_nxt;
    end
  end

  assign out_valid = a_valid_r;
  assign out_word  = a_word_r;

endmodule

`default_nettype wire

// ----- design/spline_point_evaluator.sv -----
// Top level: polynomial segment evaluator giving position, velocity and acceleration.
//
//   channel | ports               | word
//   --------+---------------------+---------------------------------------------
//   input   | in_tvalid/tready    | tdata: elapsed_time
//   result  | out_tvalid/tready   | tdata: position, velocity, acceleration;
//           |                     | tuser: saturated
//   config  | cfg_we/index/wdata  | 0 order, 1..6 coefficients 0..5
//
// One word is accepted per cycle while the result channel is not stalled. Five Horner
// steps of two stages each (multiply, then round/add/clamp) sit between an input
// register and the output register; every step runs all three lanes, with terms above
// the segment order forced to zero.
// Reset clears valid bits and loads order quintic and zero coefficients.
// Each stage holds its word while the stage after it is full and stalled, so
// bubbles close up and nothing is lost or repeated.
`default_nettype none

module spline_point_evaluator import spe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [23:0]          in_tdata,   // [23:0] elapsed_time
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [95:0]               out_tdata,  // [31:0] position, [63:32] velocity,
                                                // [95:64] acceleration
  output logic                      out_tuser,  // [0] saturated
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic [1:0] order_r;
  coef_t      coef_r [NCOEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_QUINTIC;
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER: order_r   <= cfg_wdata[1:0];
        REG_COEF0: coef_r[0] <= cfg_wdata;
        REG_COEF1: coef_r[1] <= cfg_wdata;
        REG_COEF2: coef_r[2] <= cfg_wdata;
        REG_COEF3: coef_r[3] <= cfg_wdata;
        REG_COEF4: coef_r[4] <= cfg_wdata;
        REG_COEF5: coef_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Mask terms above the order and scale derivative coefficients
  logic [2:0] top_deg;
  coef_t      cm     [NCOEF];
  acc_t       pc_nxt [NCOEF];
  acc_t       vc_nxt [NSTEP];
  acc_t       ac_nxt [NSTEP-1];
  acc_t       pc_r   [NCOEF];
  acc_t       vc_r   [NSTEP];
  acc_t       ac_r   [NSTEP-1];

  always_comb begin
    case (order_r)
      ORDER_LINEAR: top_deg = 3'd1;
      ORDER_CUBIC:  top_deg = 3'd3;
      default:      top_deg = 3'd5;
    endcase
    for (int i = 0; i < NCOEF; i++) begin
      cm[i]     = (3'(i) <= top_deg) ? coef_r[i] : '0;
      pc_nxt[i] = acc_t'(cm[i]);
    end
    for (int j = 0; j < NSTEP; j++) begin
      vc_nxt[j] = scale_coef(cm[j+1], 5'(j + 1));
    end
    for (int j = 0; j < NSTEP - 1; j++) begin
      ac_nxt[j] = scale_coef(cm[j+2], 5'((j + 2) * (j + 1)));
    end
  end

  always_ff @(posedge clk) begin
    pc_r <= pc_nxt;
    vc_r <= vc_nxt;
    ac_r <= ac_nxt;
  end

  // Input register
  logic  s0_valid_r;
  time_t s0_t_r;
  logic  s0_ready;

  logic         st_valid [NSTEP+1];
  logic         st_ready [NSTEP+1];
  horner_word_t st_word  [NSTEP+1];

  assign s0_ready  = !s0_valid_r || st_ready[0];
  // Hold off the sender while reset is applied
  assign in_tready = s0_ready && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready) begin
      s0_t_r <= in_tdata;
    end
  end

  // Seed position with its top term and the other accumulators with zero: time, pos, vel, acc, sat
  assign st_valid[0] = s0_valid_r;
  assign st_word[0]  = {s0_t_r, pc_r[NCOEF-1], {ACC_W{1'b0}}, {ACC_W{1'b0}}, 1'b0};

  // Horner steps, top term first
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    acc_t ca;
    if (k == 0) begin : g_pad
      assign ca = '0;
    end else begin : g_term
      assign ca = ac_r[NSTEP-1-k];
    end

    spe_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_word   (st_word[k]),
      .coef_pos  (pc_r[NSTEP-1-k]),
      .coef_vel  (vc_r[NSTEP-1-k]),
      .coef_acc  (ca),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_word  (st_word[k+1])
    );
  end

  // Clamp to 32 bits and hold in the output register
  function automatic logic [COEF_W:0] clamp32(input acc_t v);
    logic [COEF_W:0] res;
    if (v > acc_t'(32'sh7FFF_FFFF)) begin
      res = {1'b1, 1'b0, {(COEF_W-1){1'b1}}};
    end else if (v < acc_t'(32'sh8000_0000)) begin
      res = {1'b1, 1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      res = {1'b0, v[COEF_W-1:0]};
    end
    return res;
  endfunction

  logic            out_valid_r;
  logic [COEF_W:0] pos_c, vel_c, acc_c;
  coef_t           pos_r, vel_r, acc_r;
  logic            sat_r;
  logic            out_take;

  assign out_take                = !out_valid_r || out_tready;
  assign st_ready[NSTEP]         = out_take;

  always_comb begin
    pos_c = clamp32(st_word[NSTEP].pos);
    vel_c = clamp32(st_word[NSTEP].vel);
    acc_c = clamp32(st_word[NSTEP].acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= st_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      pos_r <= pos_c[COEF_W-1:0];
      vel_r <= vel_c[COEF_W-1:0];
      acc_r <= acc_c[COEF_W-1:0];
      sat_r <= st_word[NSTEP].sat | pos_c[COEF_W] | vel_c[COEF_W] | acc_c[COEF_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {acc_r, vel_r, pos_r};
  assign out_tuser  = sat_r;

endmodule

`default_nettype wire

// ----- tb/sv/spline_point_evaluator_test.sv -----
// Self-checking testbench for the spline point evaluator: directed and random segments, times and stalls.
`timescale 1ns / 100ps

module spline_point_evaluator_test;
  import spe_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int LONG_STALL = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PHASES = 16;
  localparam int STALL_PHASE = 6;

  // Index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  // Order code that the block treats as quintic
  localparam logic [1:0] ORDER_SPARE = 2'd3;

  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic [COEF_W-1:0] COEF_ONE = 32'h0001_0000;
  localparam logic [TIME_W-1:0] T_MAX = 24'hFF_FFFF;
  localparam logic [TIME_W-1:0] T_ONE = 24'h01_0000;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               saturated;
  } motion_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [95:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ORDER;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  // Segment as the block should hold it
  logic [1:0]         order_model = ORDER_QUINTIC;
  logic signed [31:0] coef_model [NCOEF];

  logic [TIME_W-1:0] time_backlog [$];
  motion_t           motion_due [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                tx_gap = 0;
  int                tx_burst = 0;
  int                rx_hold = 0;
  int                rx_burst = 0;
  bit                stall_request = 1'b0;
  bit                stall_done = 1'b0;

  spline_point_evaluator #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [23:0] elapsed_time
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] position, [63:32] velocity, [95:64] acceleration
    .out_tuser  (out_tuser),   // [0] saturated
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp v into [lo, hi], noting any clip
  function automatic longint clip(input longint v, input longint lo, input longint hi,
                                  inout bit sat);
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // Coefficient k of derivative lane (0 position, 1 velocity, 2 acceleration)
  function automatic longint lane_coef(input int lane, input int k);
    longint factor;
    case (lane)
      0: factor = 1;
      1: factor = k + 1;
      default: factor = (k + 2) * (k + 1);
    endcase
    return factor * longint'(coef_model[k + lane]);
  endfunction

  // Horner evaluation of one lane in the 40-bit accumulator
  function automatic longint lane_value(input int lane, input int deg, input longint t,
                                        inout bit sat);
    longint acc;
    int n;
    n = deg + 1 - lane;
    if (n <= 0) return 0;
    acc = clip(lane_coef(lane, n - 1), longint'(ACC_MIN), longint'(ACC_MAX), sat);
    for (int k = n - 2; k >= 0; k--) begin
      acc = ((acc * t + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + lane_coef(lane, k);
      acc = clip(acc, longint'(ACC_MIN), longint'(ACC_MAX), sat);
    end
    return clip(acc, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1, sat);
  endfunction

  function automatic motion_t predict_motion(input logic [TIME_W-1:0] t);
    motion_t m;
    bit sat;
    int deg;
    longint p;
    longint v;
    longint a;
    sat = 1'b0;
    case (order_model)
      ORDER_LINEAR: deg = 1;
      ORDER_CUBIC: deg = 3;
      default: deg = 5;
    endcase
    p = lane_value(0, deg, longint'(t), sat);
    v = lane_value(1, deg, longint'(t), sat);
    a = lane_value(2, deg, longint'(t), sat);
    m.position = p[31:0];
    m.velocity = v[31:0];
    m.acceleration = a[31:0];
    m.saturated = sat;
    return m;
  endfunction

  // Idle gap: mostly none, some short, a few long, with gap-free bursts
  function automatic int draw_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coefficient: extremes, full range, or a value of random magnitude
  function automatic logic [COEF_W-1:0] draw_coef(input int span);
    int r;
    logic [COEF_W-1:0] c;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: c = COEF_MAX;
      1: c = COEF_MIN;
      2: c = '0;
      default: c = '1;
    endcase
    if (r < 8) return c;
    if (r < 30) return $urandom;
    c = $urandom & ((32'd1 << $urandom_range(4, span)) - 1);
    if ($urandom_range(0, 1)) c = -c;
    return c;
  endfunction

  function automatic logic [TIME_W-1:0] draw_time(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return T_MAX;
        2: return 24'd1;
        default: return T_ONE;
      endcase
    end
    if (r < 35) return TIME_W'($urandom_range(0, T_MAX));
    return TIME_W'($urandom & ((32'd1 << span) - 1));
  endfunction

  // Wait until no word is pending, offered or in flight
  task automatic wait_idle();
    @(negedge clk);
    while (time_backlog.size() != 0 || in_tvalid || motion_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_ORDER) order_model = val[1:0];
    else if (idx >= REG_COEF0 && idx <= REG_COEF5) coef_model[idx - REG_COEF0] = val;
  endtask

  // Load a whole segment while idle; optionally add a write to the unused index
  task automatic load_segment(input logic [1:0] ord, input logic [COEF_W-1:0] c0,
                              input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
                              input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c4,
                              input logic [COEF_W-1:0] c5, input bit stray);
    wait_idle();
    write_reg(REG_ORDER, {{(COEF_W-2){1'b0}}, ord});
    write_reg(REG_COEF0, c0);
    write_reg(REG_COEF1, c1);
    write_reg(REG_COEF2, c2);
    write_reg(REG_COEF3, c3);
    write_reg(REG_COEF4, c4);
    write_reg(REG_COEF5, c5);
    if (stray) write_reg(REG_NONE, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Sender: offer backlog words with random gaps; predict on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) motion_due.push_back(predict_motion(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (time_backlog.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= time_backlog.pop_front();
          tx_gap = draw_gap(tx_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result word, then pick the next ready value
  always @(posedge clk) begin
    motion_t want;
    if (out_tvalid && out_tready) begin
      if (motion_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: actual %h / %b", $time, out_tdata,
                 out_tuser);
      end else begin
        want = motion_due.pop_front();
        if ($signed(out_tdata[31:0]) != want.position) begin
          mismatches++;
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   $signed(out_tdata[31:0]));
        end
        if ($signed(out_tdata[63:32]) != want.velocity) begin
          mismatches++;
          $display("%0t: velocity expected %0d actual %0d", $time, want.velocity,
                   $signed(out_tdata[63:32]));
        end
        if ($signed(out_tdata[95:64]) != want.acceleration) begin
          mismatches++;
          $display("%0t: acceleration expected %0d actual %0d", $time, want.acceleration,
                   $signed(out_tdata[95:64]));
        end
        if (out_tuser != want.saturated) begin
          mismatches++;
          $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                   out_tuser);
        end
      end
    end
    if (rst_n) begin
      // Hold off once for a long stretch so the pipeline backs up
      if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        rx_hold = LONG_STALL;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_hold = draw_gap(rx_burst);
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int span_c;
    int span_t;
    int count;
    for (int i = 0; i < NCOEF; i++) coef_model[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset segment: quintic with zero coefficients
    time_backlog.push_back('0);
    time_backlog.push_back(T_MAX);

    // Linear: higher coefficients must be ignored
    load_segment(ORDER_LINEAR, 32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, 32'hFFF0_0000,
                 32'h0123_4567, COEF_MAX, 1'b0);
    time_backlog.push_back('0);
    time_backlog.push_back(T_ONE);
    time_backlog.push_back(24'h00_8000);
    time_backlog.push_back(T_MAX);

    // Cubic: fourth and fifth powers ignored
    load_segment(ORDER_CUBIC, COEF_ONE, 32'hFFFF_8000, 32'h0000_4000, 32'hFFFF_F000,
                 COEF_MIN, COEF_MAX, 1'b0);
    time_backlog.push_back(24'h01_8000);
    time_backlog.push_back(24'd1);
    time_backlog.push_back(24'h03_0000);

    // Quintic with small mixed-sign terms
    load_segment(ORDER_QUINTIC, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_C000, 32'h0000_2000,
                 32'hFFFF_FF00, 32'h0000_0010, 1'b0);
    time_backlog.push_back(24'h00_8000);
    time_backlog.push_back(24'h02_0000);
    time_backlog.push_back(24'h7F_FFFF);

    // Order code three behaves as quintic
    load_segment(ORDER_SPARE, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_C000, 32'h0000_2000,
                 32'hFFFF_FF00, 32'h0000_0010, 1'b0);
    time_backlog.push_back(24'h02_0000);
    time_backlog.push_back(24'h00_8001);

    // All coefficients at the positive extreme: saturation
    load_segment(ORDER_QUINTIC, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                 1'b0);
    time_backlog.push_back('0);
    time_backlog.push_back(24'd1);
    time_backlog.push_back(T_MAX);

    // All coefficients at the negative extreme
    load_segment(ORDER_QUINTIC, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                 1'b0);
    time_backlog.push_back(T_MAX);
    time_backlog.push_back(T_ONE);

    // A write to the unused index must leave the segment alone
    load_segment(ORDER_CUBIC, 32'h0000_1000, 32'hFFFF_F000, 32'h0001_0000, 32'h0000_0100,
                 32'h0, 32'h0, 1'b1);
    time_backlog.push_back(T_ONE);
    time_backlog.push_back(24'h00_1234);

    // Random segments with random times
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      span_c = $urandom_range(8, 30);
      span_t = $urandom_range(12, 24);
      load_segment(2'($urandom_range(0, 3)), draw_coef(span_c), draw_coef(span_c),
                   draw_coef(span_c), draw_coef(span_c), draw_coef(span_c),
                   draw_coef(span_c), $urandom_range(0, 7) == 0);
      count = (ph == STALL_PHASE) ? 60 : $urandom_range(35, 50);
      if (ph == STALL_PHASE) stall_request = 1'b1;
      repeat (count) time_backlog.push_back(draw_time(span_t));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- spline_point_evaluator.f -----
design/spe_pkg.sv
design/spe_step.sv
design/spline_point_evaluator.sv
tb/sv/spline_point_evaluator_test.sv
